// ===== hdl/pqc_pkg.sv =====
// ----------------------------------------------------------------------------
// pqc_pkg
// shared types and constants of the pulse quality classifier
// ----------------------------------------------------------------------------
package pqc_pkg;

    // fixed field widths
    localparam int SAMPLE_IN_W  = 16;
    localparam int PED_IN_W     = 19;
    localparam int HEIGHT_W     = 20;
    localparam int DIFF_W       = HEIGHT_W + 1;
    localparam int SCOUNT_W     = 8;
    localparam int COUNT_OUT_W  = 32;
    localparam int NUM_CNT      = 6;
    localparam int NUM_FLAGS    = 6;

    // stream payload widths
    localparam int IN_TDATA_W   = 40;
    localparam int OUT_TDATA_W  = 200;

    // queue between front and back
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam int CFG_IDX_W              = 2;
    localparam int CFG_DATA_W             = 16;
    localparam logic [1:0] REG_NEG_POLARITY = 2'd0;
    localparam logic [1:0] REG_TRIG_THRESH  = 2'd1;
    localparam logic [1:0] REG_FULL_SCALE   = 2'd2;
    localparam logic [1:0] REG_MIN_SAMPLES  = 2'd3;

    // configuration reset values
    localparam logic        RST_NEG_POLARITY = 1'b1;
    localparam logic [15:0] RST_TRIG_THRESH  = 16'd15460;
    localparam logic [15:0] RST_FULL_SCALE   = 16'd16383;
    localparam logic [7:0]  RST_MIN_SAMPLES  = 8'd8;

    // counter slots
    localparam int CNT_TOTAL    = 0;
    localparam int CNT_TRIGLESS = 1;
    localparam int CNT_OVERFLOW = 2;
    localparam int CNT_VALID    = 3;
    localparam int CNT_ACCEPT   = 4;
    localparam int CNT_ACC_VETO = 5;

    // flag positions in the result
    localparam int FLG_COUNTED  = 0;
    localparam int FLG_OVERFLOW = 1;
    localparam int FLG_TRIGLESS = 2;
    localparam int FLG_VALID    = 3;
    localparam int FLG_ACCEPT   = 4;
    localparam int FLG_ACC_VETO = 5;

    typedef struct packed {
        logic        negative_polarity;
        logic [15:0] trigger_threshold;
        logic [15:0] adc_full_scale;
        logic [7:0]  min_pulse_samples;
    } pqc_cfg_t;

    // one finished pulse, handed from front to back
    typedef struct packed {
        logic                counted;
        logic                overflowed;
        logic                pileup;
        logic                veto;
        logic                matched;
        logic [HEIGHT_W-1:0] peak_x8;
        logic [HEIGHT_W-1:0] pedestal_x8;
    } pqc_rec_t;

    typedef struct packed {
        logic [NUM_CNT-1:0][COUNT_OUT_W-1:0] counts;
        logic [NUM_FLAGS-1:0]                flags;
    } pqc_result_t;

endpackage

// ===== hdl/pqc_front.sv =====
// ----------------------------------------------------------------------------
// pqc_front
// per-sample pulse tracker: pedestal, running peak, overflow and length
// ----------------------------------------------------------------------------
module pqc_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pqc_pkg::pqc_cfg_t              cfg,
    input  logic                           sample_valid,
    output logic                           sample_ready,
    input  logic [pqc_pkg::SAMPLE_IN_W-1:0] sample_value,
    input  logic                           pulse_first,
    input  logic                           pulse_last,
    input  logic [pqc_pkg::PED_IN_W-1:0]   pedestal_x8,
    input  logic                           pileup_flag,
    input  logic                           veto_flag,
    input  logic                           tdc_matched,
    input  logic                           queue_full,
    output logic                           rec_push,
    output pqc_pkg::pqc_rec_t              rec
);

    localparam int DW = pqc_pkg::DIFF_W;
    localparam int HW = pqc_pkg::HEIGHT_W;
    localparam int CW = pqc_pkg::SCOUNT_W;

    logic [HW-1:0] peak_reg, peak_next;
    logic [HW-1:0] ped_reg, ped_next;
    logic [CW-1:0] scount_reg, scount_next;
    logic          ovf_reg, ovf_next;

    logic                   accept;
    logic [SAMPLE_BITS-1:0] adc;
    logic [15:0]            adc16;
    logic [HW-1:0]          ped_eff, peak_base, peak_upd;
    logic [CW-1:0]          scount_base, scount_upd;
    logic                   ovf_base, ovf_hit;
    logic signed [DW-1:0]   s8, p8, height;

    assign sample_ready = !queue_full;
    assign accept       = sample_valid && sample_ready;

    assign adc   = sample_value[SAMPLE_BITS-1:0];
    assign adc16 = 16'(adc);

    // a first mark restarts the pulse before this sample is applied
    assign ped_eff     = pulse_first ? HW'(pedestal_x8) : ped_reg;
    assign peak_base   = pulse_first ? '0 : peak_reg;
    assign scount_base = pulse_first ? '0 : scount_reg;
    assign ovf_base    = pulse_first ? 1'b0 : ovf_reg;

    assign scount_upd = (scount_base == '1) ? scount_base : scount_base + CW'(1);

    assign ovf_hit = cfg.negative_polarity ? (adc16 == '0) : (adc16 >= cfg.adc_full_scale);

    assign s8     = $signed(DW'({adc, 3'b000}));
    assign p8     = $signed(DW'(ped_eff));
    assign height = cfg.negative_polarity ? (p8 - s8) : (s8 - p8);

    // peak freezes once overflow has been seen in this pulse
    assign peak_upd = (!ovf_base && !ovf_hit && (height > $signed(DW'(peak_base))))
                      ? height[HW-1:0] : peak_base;

    always_comb
    begin
        peak_next   = peak_reg;
        ped_next    = ped_reg;
        scount_next = scount_reg;
        ovf_next    = ovf_reg;
        if (accept)
        begin
            ped_next = ped_eff;
            if (pulse_last)
            begin
                peak_next   = '0;
                scount_next = '0;
                ovf_next    = 1'b0;
            end
            else
            begin
                peak_next   = peak_upd;
                scount_next = scount_upd;
                ovf_next    = ovf_base | ovf_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg   <= '0;
            ped_reg    <= '0;
            scount_reg <= '0;
            ovf_reg    <= 1'b0;
        end
        else
        begin
            peak_reg   <= peak_next;
            ped_reg    <= ped_next;
            scount_reg <= scount_next;
            ovf_reg    <= ovf_next;
        end
    end

    assign rec_push        = accept && pulse_last;
    assign rec.counted     = scount_upd >= cfg.min_pulse_samples;
    assign rec.overflowed  = ovf_base | ovf_hit;
    assign rec.pileup      = pileup_flag;
    assign rec.veto        = veto_flag;
    assign rec.matched     = tdc_matched;
    assign rec.peak_x8     = peak_upd;
    assign rec.pedestal_x8 = ped_eff;

endmodule

// ===== hdl/pqc_queue.sv =====
// ----------------------------------------------------------------------------
// pqc_queue
// small show-ahead queue of finished pulses between tracker and tally
// ----------------------------------------------------------------------------
module pqc_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pqc_pkg::pqc_rec_t push_rec,
    output logic              full,
    input  logic              pop,
    output logic              pop_valid,
    output pqc_pkg::pqc_rec_t pop_rec
);

    localparam int PW = pqc_pkg::QPTR_W;
    localparam int NW = pqc_pkg::QCNT_W;

    pqc_pkg::pqc_rec_t slot_reg [pqc_pkg::QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] level_reg, level_next;
    logic          do_push, do_pop;

    assign full      = (level_reg == NW'(pqc_pkg::QUEUE_DEPTH));
    assign pop_valid = (level_reg != '0);
    assign pop_rec   = slot_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(pqc_pkg::QUEUE_DEPTH - 1)) ? '0
                          : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(pqc_pkg::QUEUE_DEPTH - 1)) ? '0
                          : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            level_next = level_reg + NW'(1);
        end
        else if (do_pop && !do_push)
        begin
            level_next = level_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

// ===== hdl/pqc_back.sv =====
// ----------------------------------------------------------------------------
// pqc_back
// pulse classification, saturating event counters and result register
// ----------------------------------------------------------------------------
module pqc_back #(
    parameter int COUNTER_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pqc_pkg::pqc_cfg_t    cfg,
    input  logic                 rec_valid,
    input  pqc_pkg::pqc_rec_t    rec,
    output logic                 rec_pop,
    output logic                 result_valid,
    input  logic                 result_ready,
    output pqc_pkg::pqc_result_t result
);

    localparam int DW = pqc_pkg::DIFF_W;

    logic [COUNTER_BITS-1:0] cnt_reg  [pqc_pkg::NUM_CNT];
    logic [COUNTER_BITS-1:0] cnt_next [pqc_pkg::NUM_CNT];
    logic                    valid_reg, valid_next;
    pqc_pkg::pqc_result_t    result_reg, result_next;

    logic                        load;
    logic signed [DW-1:0]        t8, p8, tps, peak;
    logic                        trig, ovf, good, acc, accv;
    logic [pqc_pkg::NUM_CNT-1:0] hit;

    assign load    = rec_valid && (!valid_reg || result_ready);
    assign rec_pop = load;

    assign t8   = $signed(DW'({cfg.trigger_threshold, 3'b000}));
    assign p8   = $signed(DW'(rec.pedestal_x8));
    assign peak = $signed(DW'(rec.peak_x8));
    assign tps  = cfg.negative_polarity ? (p8 - t8) : (t8 - p8);

    // pedestal already at or past the threshold on the pulse side is triggerless too
    assign trig = rec.counted && ((peak < tps)
                  || (!cfg.negative_polarity && (p8 >= t8))
                  || (cfg.negative_polarity && (p8 <= t8)));
    assign ovf  = rec.counted && rec.overflowed;
    assign good = rec.counted && !(rec.pileup || rec.overflowed || trig);
    assign acc  = good && rec.matched;
    assign accv = acc && rec.veto;

    always_comb
    begin
        hit                        = '0;
        hit[pqc_pkg::CNT_TOTAL]    = rec.counted;
        hit[pqc_pkg::CNT_TRIGLESS] = trig;
        hit[pqc_pkg::CNT_OVERFLOW] = ovf;
        hit[pqc_pkg::CNT_VALID]    = good;
        hit[pqc_pkg::CNT_ACCEPT]   = acc;
        hit[pqc_pkg::CNT_ACC_VETO] = accv;
    end

    always_comb
    begin
        valid_next  = valid_reg;
        result_next = result_reg;
        for (int k = 0; k < pqc_pkg::NUM_CNT; k++)
        begin
            cnt_next[k] = cnt_reg[k];
            if (load && hit[k] && (cnt_reg[k] != '1))
            begin
                cnt_next[k] = cnt_reg[k] + COUNTER_BITS'(1);
            end
        end
        if (load)
        begin
            valid_next = 1'b1;
            result_next.flags[pqc_pkg::FLG_COUNTED]  = rec.counted;
            result_next.flags[pqc_pkg::FLG_OVERFLOW] = ovf;
            result_next.flags[pqc_pkg::FLG_TRIGLESS] = trig;
            result_next.flags[pqc_pkg::FLG_VALID]    = good;
            result_next.flags[pqc_pkg::FLG_ACCEPT]   = acc;
            result_next.flags[pqc_pkg::FLG_ACC_VETO] = accv;
            for (int k = 0; k < pqc_pkg::NUM_CNT; k++)
            begin
                result_next.counts[k] = pqc_pkg::COUNT_OUT_W'(cnt_next[k]);
            end
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            for (int k = 0; k < pqc_pkg::NUM_CNT; k++)
            begin
                cnt_reg[k] <= '0;
            end
        end
        else
        begin
            valid_reg <= valid_next;
            for (int k = 0; k < pqc_pkg::NUM_CNT; k++)
            begin
                cnt_reg[k] <= cnt_next[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== hdl/pulse_quality_classifier_top.sv =====
// ----------------------------------------------------------------------------
// pulse_quality_classifier_top
// waveform pulse classifier with saturating quality counters
// ----------------------------------------------------------------------------
// Takes one waveform sample per clock while the queue is not full, with no gaps between pulses.
// The rate is set by the sample tracker, which does one pedestal subtract and
// one peak compare per sample. On the last sample of a pulse the tracker hands
// a record to a four-entry queue; the tally stage classifies it, updates the
// six saturating counters and loads the result register. A result passes through
// the queue and the result register before it is presented on the output. The
// input stalls only when the queue is full, i.e. when the output holds one result
// back and four more wait behind it.
// Configuration is always ready and must be written while no pulse is in flight.
module pulse_quality_classifier_top #(
    parameter int SAMPLE_BITS  = 16,
    parameter int COUNTER_BITS = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // sample stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] sample_value, [34:16] pedestal_x8, [35] pileup_flag,
    // [36] veto_flag, [37] tdc_matched, [39:38] zero
    input  logic [pqc_pkg::IN_TDATA_W-1:0]    s_tdata,
    // [0] pulse_first
    input  logic                              s_tuser,
    input  logic                              s_tlast,
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] pulse_counted, [1] overflowed, [2] triggerless, [3] valid_pulse,
    // [4] accepted, [5] accepted_vetoed, [37:6] total_count,
    // [69:38] triggerless_count, [101:70] overflow_count, [133:102] valid_count,
    // [165:134] accept_count, [197:166] accepted_veto_count, [199:198] zero
    output logic [pqc_pkg::OUT_TDATA_W-1:0]   m_tdata,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pqc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pqc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    pqc_pkg::pqc_cfg_t    cfg_reg, cfg_next;
    pqc_pkg::pqc_rec_t    push_rec, pop_rec;
    pqc_pkg::pqc_result_t result;
    logic                 rec_push, queue_full, rec_pop, rec_valid;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pqc_pkg::REG_NEG_POLARITY: cfg_next.negative_polarity = cfg_data[0];
                pqc_pkg::REG_TRIG_THRESH:  cfg_next.trigger_threshold = cfg_data;
                pqc_pkg::REG_FULL_SCALE:   cfg_next.adc_full_scale    = cfg_data;
                pqc_pkg::REG_MIN_SAMPLES:  cfg_next.min_pulse_samples = cfg_data[7:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.negative_polarity <= pqc_pkg::RST_NEG_POLARITY;
            cfg_reg.trigger_threshold <= pqc_pkg::RST_TRIG_THRESH;
            cfg_reg.adc_full_scale    <= pqc_pkg::RST_FULL_SCALE;
            cfg_reg.min_pulse_samples <= pqc_pkg::RST_MIN_SAMPLES;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    pqc_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .sample_valid (s_tvalid),
        .sample_ready (s_tready),
        .sample_value (s_tdata[15:0]),
        .pulse_first  (s_tuser),
        .pulse_last   (s_tlast),
        .pedestal_x8  (s_tdata[34:16]),
        .pileup_flag  (s_tdata[35]),
        .veto_flag    (s_tdata[36]),
        .tdc_matched  (s_tdata[37]),
        .queue_full   (queue_full),
        .rec_push     (rec_push),
        .rec          (push_rec)
    );

    pqc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_rec  (push_rec),
        .full      (queue_full),
        .pop       (rec_pop),
        .pop_valid (rec_valid),
        .pop_rec   (pop_rec)
    );

    pqc_back #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .rec_valid    (rec_valid),
        .rec          (pop_rec),
        .rec_pop      (rec_pop),
        .result_valid (m_tvalid),
        .result_ready (m_tready),
        .result       (result)
    );

    // padding bits above the counters stay zero
    assign m_tdata = pqc_pkg::OUT_TDATA_W'({result.counts, result.flags});

endmodule

// ===== hdl/pqc_checker.sv =====
// ----------------------------------------------------------------------------
// pqc_checker
// port-level checks on the result stream of the pulse classifier
// ----------------------------------------------------------------------------
module pqc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [pqc_pkg::OUT_TDATA_W-1:0] m_tdata
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an uncounted pulse carries no class flags
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[0] |-> (m_tdata[5:1] == 5'b00000))
        else $error("flags set on uncounted pulse");

    // accepted-vetoed implies accepted implies valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[5] && !m_tdata[4]) && !(m_tdata[4] && !m_tdata[3]))
        else $error("accept flags out of order");

    // a valid pulse neither overflowed nor missed the trigger
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[3] |-> !m_tdata[1] && !m_tdata[2])
        else $error("valid pulse with overflow or triggerless");

endmodule

bind pulse_quality_classifier_top pqc_checker u_pqc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
